// File: rtl/core/assert_macros.svh
// assertion shorthands for the range max subarray sum tree checkers
// expects signals named clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/rmss_pkg.sv
// shared types, constants and span arithmetic for the max subarray sum tree
// no dependencies
package rmss_pkg;

    localparam int DEF_CAPACITY = 4096;
    localparam int LEN_W        = 13;
    localparam int VAL_W        = 16;
    localparam int SUM_W        = 28;
    localparam int STORE_W      = 32;
    localparam int ACC_W        = 34;

    localparam logic OP_SET   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic signed [ACC_W-1:0] SUM_MAX = ACC_W'(134217727);
    localparam logic signed [ACC_W-1:0] SUM_MIN = -ACC_W'(134217728);

    typedef struct packed {
        logic signed [STORE_W-1:0] total;
        logic signed [STORE_W-1:0] pre;
        logic signed [STORE_W-1:0] suf;
        logic signed [STORE_W-1:0] inner;
    } node_word_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] total;
        logic signed [ACC_W-1:0] pre;
        logic signed [ACC_W-1:0] suf;
        logic signed [ACC_W-1:0] inner;
    } span_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_SDESC,
        ST_UP,
        ST_RDL,
        ST_RDR,
        ST_JOIN,
        ST_QDESC,
        ST_QACC,
        ST_RES
    } state_t;

    typedef struct packed {
        logic clr_step;
        logic load_item;
        logic desc_step;
        logic rd_node;
        logic rd_left;
        logic rd_right;
        logic hold_left;
        logic acc_take;
        logic leaf_write;
        logic up_step;
        logic join_write;
        logic res_load;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic is_query;
        logic set_ok;
        logic query_err;
        logic leaf;
        logic take;
        logic at_root;
        logic last_piece;
    } stat_t;

    function automatic logic signed [ACC_W-1:0] larger(logic signed [ACC_W-1:0] a,
                                                        logic signed [ACC_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic span_t widen(node_word_t w);
        span_t s;
        s.total = ACC_W'(w.total);
        s.pre   = ACC_W'(w.pre);
        s.suf   = ACC_W'(w.suf);
        s.inner = ACC_W'(w.inner);
        return s;
    endfunction

    function automatic node_word_t narrow(span_t s);
        node_word_t w;
        w.total = s.total[STORE_W-1:0];
        w.pre   = s.pre[STORE_W-1:0];
        w.suf   = s.suf[STORE_W-1:0];
        w.inner = s.inner[STORE_W-1:0];
        return w;
    endfunction

    function automatic span_t span_join(span_t l, span_t r);
        span_t s;
        s.total = l.total + r.total;
        s.pre   = larger(l.pre, l.total + r.pre);
        s.suf   = larger(r.suf, r.total + l.suf);
        s.inner = larger(larger(l.inner, r.inner), l.suf + r.pre);
        return s;
    endfunction

    function automatic logic signed [SUM_W-1:0] sat_sum(logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] c;
        c = v;
        if (v > SUM_MAX)
            c = SUM_MAX;
        else if (v < SUM_MIN)
            c = SUM_MIN;
        return c[SUM_W-1:0];
    endfunction

endpackage

// File: rtl/core/rmss_req_if.sv
// request channel: valid/ready plus one operation word
// depends on rmss_pkg
interface rmss_req_if
    import rmss_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    operation;
    logic [LEN_W-1:0]        first_index;
    logic [LEN_W-1:0]        last_index;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, operation, first_index, last_index, value, input ready);
    modport sink   (input valid, operation, first_index, last_index, value, output ready);
endinterface

// File: rtl/core/rmss_rsp_if.sv
// response channel: valid/ready plus one result word
// depends on rmss_pkg
interface rmss_rsp_if
    import rmss_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] best_sum;
    logic                    range_error;

    modport source (output valid, best_sum, range_error, input ready);
    modport sink   (input valid, best_sum, range_error, output ready);
endinterface

// File: rtl/core/range_max_subarray_sum_tree_top.sv
// Range maximum subarray sum over a segment tree of signed 16-bit elements.
// Positions run 1..length_in_use; node 1 covers the whole array and a node
// over b..e splits at (b+e)/2. A set word (operation 0) writes one leaf and
// recombines every ancestor; it gives no response. A query word (operation 1)
// returns the largest non-empty contiguous sum in first..last, or
// range_error with best_sum 0 when the range is bad. The node memory has one
// read and one write port, and that single port sets the timing: a set accepts
// and checks the word, steps down one level at a time and writes the leaf,
// then for each level going up steps up, reads each child and writes the
// parent. A query walks from the root once for each of the tree nodes that
// tile the range and folds each of them in. After reset, and after every
// write to length_in_use, the tree is zeroed by a sweep over all 4*CAPACITY
// node slots (16384 at the default), during which no word is accepted. One
// item is in flight at a time; a finished result sits in an output register,
// so the next word is taken while it waits.
// depends on rmss_pkg, rmss_req_if, rmss_rsp_if, rmss_dp, rmss_ctrl
module range_max_subarray_sum_tree_top
    import rmss_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)(
    input  logic             clk,
    input  logic             rst_n,
    rmss_req_if.sink         req,
    rmss_rsp_if.source       rsp,
    input  logic             cfg_wr_en,
    input  logic [LEN_W-1:0] cfg_wr_data
);
    cmd_t  cmd;
    stat_t stat;

    // sequencer: clearing sweep, descent, ascent, query tiling
    rmss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // node memory and span arithmetic
    rmss_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_operation   (req.operation),
        .in_first_index (req.first_index),
        .in_last_index  (req.last_index),
        .in_value       (req.value),
        .cmd            (cmd),
        .stat           (stat),
        .best_sum       (rsp.best_sum),
        .range_error    (rsp.range_error)
    );
endmodule

// File: rtl/core/rmss_dp.sv
// datapath: node memory, walk registers, span accumulator and result word
// depends on rmss_pkg
module rmss_dp
    import rmss_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [LEN_W-1:0]        cfg_wr_data,
    input  logic                    in_operation,
    input  logic [LEN_W-1:0]        in_first_index,
    input  logic [LEN_W-1:0]        in_last_index,
    input  logic signed [VAL_W-1:0] in_value,
    input  cmd_t                    cmd,
    output stat_t                   stat,
    output logic signed [SUM_W-1:0] best_sum,
    output logic                    range_error
);
    localparam int SLOTS  = 4 * CAPACITY;
    localparam int NODE_W = $clog2(SLOTS);
    localparam int CAP_W  = $clog2(CAPACITY + 1);
    localparam int PW     = ((CAP_W > LEN_W) ? CAP_W : LEN_W) + 1;

    logic [PW-1:0]     len_reg, len_next;
    logic [NODE_W-1:0] clr_cnt_reg;
    logic              first_piece_reg;

    logic                    op_reg;
    logic [PW-1:0]           first_reg, last_reg;
    logic signed [VAL_W-1:0] val_reg;
    logic [PW-1:0]           b_reg, e_reg, pos_reg;
    logic [NODE_W-1:0]       node_reg;
    span_t                   acc_reg;
    node_word_t              left_reg;
    node_word_t              rd_reg;
    logic signed [SUM_W-1:0] best_sum_reg;
    logic                    range_error_reg;

    node_word_t mem [SLOTS];

    logic [PW:0]       mid_sum;
    logic [PW-1:0]     mid;
    logic [PW-1:0]     wr_len;
    logic              mem_we;
    logic [NODE_W-1:0] wr_addr, rd_addr;
    node_word_t        wr_data, leaf_word;
    span_t             rd_span;

    assign wr_len = PW'(cfg_wr_data);
    always_comb
    begin
        len_next = wr_len;
        if (wr_len == '0)
            len_next = PW'(1);
        else if (wr_len > PW'(CAPACITY))
            len_next = PW'(CAPACITY);
    end

    assign mid_sum = {1'b0, b_reg} + {1'b0, e_reg};
    assign mid     = mid_sum[PW:1];
    assign rd_span = widen(rd_reg);

    assign leaf_word.total = STORE_W'(val_reg);
    assign leaf_word.pre   = STORE_W'(val_reg);
    assign leaf_word.suf   = STORE_W'(val_reg);
    assign leaf_word.inner = STORE_W'(val_reg);

    // write port: clearing sweep, leaf store or recombined parent
    always_comb
    begin
        mem_we  = cmd.clr_step | cmd.leaf_write | cmd.join_write;
        wr_addr = node_reg;
        wr_data = narrow(span_join(widen(left_reg), rd_span));
        priority if (cmd.clr_step)
        begin
            wr_addr = clr_cnt_reg;
            wr_data = '0;
        end
        else if (cmd.leaf_write)
            wr_data = leaf_word;
    end

    always_comb
    begin
        priority if (cmd.rd_left)
            rd_addr = NODE_W'({node_reg, 1'b0});
        else if (cmd.rd_right)
            rd_addr = NODE_W'({node_reg, 1'b1});
        else
            rd_addr = node_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= wr_data;
        rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg         <= PW'(CAPACITY);
            clr_cnt_reg     <= '0;
            first_piece_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                len_reg     <= len_next;
                clr_cnt_reg <= '0;
            end
            else if (cmd.clr_step)
                clr_cnt_reg <= clr_cnt_reg + NODE_W'(1);
            if (cmd.load_item)
                first_piece_reg <= 1'b1;
            else if (cmd.acc_take)
                first_piece_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg    <= in_operation;
            first_reg <= PW'(in_first_index);
            last_reg  <= PW'(in_last_index);
            val_reg   <= in_value;
            pos_reg   <= PW'(in_first_index);
            b_reg     <= PW'(1);
            e_reg     <= len_reg;
            node_reg  <= NODE_W'(1);
        end
        else if (cmd.desc_step)
        begin
            if (pos_reg <= mid)
            begin
                e_reg    <= mid;
                node_reg <= NODE_W'({node_reg, 1'b0});
            end
            else
            begin
                b_reg    <= mid + PW'(1);
                node_reg <= NODE_W'({node_reg, 1'b1});
            end
        end
        else if (cmd.acc_take)
        begin
            // next piece starts right after this one, walk again from the root
            pos_reg  <= e_reg + PW'(1);
            b_reg    <= PW'(1);
            e_reg    <= len_reg;
            node_reg <= NODE_W'(1);
        end
        else if (cmd.up_step)
            node_reg <= node_reg >> 1;

        if (cmd.acc_take)
            acc_reg <= first_piece_reg ? rd_span : span_join(acc_reg, rd_span);
        if (cmd.hold_left)
            left_reg <= rd_reg;
        if (cmd.res_load)
        begin
            best_sum_reg    <= stat.query_err ? '0 : sat_sum(acc_reg.inner);
            range_error_reg <= stat.query_err;
        end
    end

    assign stat.clr_done   = (clr_cnt_reg == NODE_W'(SLOTS - 1));
    assign stat.is_query   = (op_reg == OP_QUERY);
    assign stat.set_ok     = (first_reg != '0) && (first_reg <= len_reg);
    assign stat.query_err  = (first_reg == '0) || (first_reg > last_reg) ||
                             (last_reg > len_reg);
    assign stat.leaf       = (b_reg == e_reg);
    assign stat.take       = (b_reg == pos_reg) && (e_reg <= last_reg);
    assign stat.at_root    = (node_reg == NODE_W'(1));
    assign stat.last_piece = (e_reg >= last_reg);

    assign best_sum    = best_sum_reg;
    assign range_error = range_error_reg;
endmodule

// File: rtl/core/rmss_ctrl.sv
// controller: sequences clearing, set walks and query walks
// depends on rmss_pkg
module rmss_ctrl
    import rmss_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  cfg_wr_en,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output cmd_t  cmd
);
    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (stat.clr_done)
                    state_next = ST_IDLE;
            ST_IDLE:
                if (in_valid)
                    state_next = ST_CHECK;
            ST_CHECK:
                priority if (stat.is_query)
                    state_next = stat.query_err ? ST_RES : ST_QDESC;
                else if (stat.set_ok)
                    state_next = ST_SDESC;
                else
                    state_next = ST_IDLE;
            ST_SDESC:
                if (stat.leaf)
                    state_next = stat.at_root ? ST_IDLE : ST_UP;
            ST_UP:
                state_next = ST_RDL;
            ST_RDL:
                state_next = ST_RDR;
            ST_RDR:
                state_next = ST_JOIN;
            ST_JOIN:
                state_next = stat.at_root ? ST_IDLE : ST_UP;
            ST_QDESC:
                if (stat.take)
                    state_next = ST_QACC;
            ST_QACC:
                state_next = stat.last_piece ? ST_RES : ST_QDESC;
            ST_RES:
                if (!out_valid_reg)
                    state_next = ST_IDLE;
            default:
                state_next = ST_CLEAR;
        endcase
        if (cfg_wr_en)
            state_next = ST_CLEAR;
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR: cmd.clr_step  = 1'b1;
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            ST_CHECK: ;
            ST_SDESC:
            begin
                cmd.leaf_write = stat.leaf;
                cmd.desc_step  = !stat.leaf;
            end
            ST_UP:    cmd.up_step = 1'b1;
            ST_RDL:   cmd.rd_left = 1'b1;
            ST_RDR:
            begin
                cmd.rd_right  = 1'b1;
                cmd.hold_left = 1'b1;
            end
            ST_JOIN:  cmd.join_write = 1'b1;
            ST_QDESC:
            begin
                cmd.rd_node   = stat.take;
                cmd.desc_step = !stat.take;
            end
            ST_QACC:  cmd.acc_take = 1'b1;
            ST_RES:   cmd.res_load = !out_valid_reg;
            default: ;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (cmd.res_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
endmodule

// File: rtl/core/rmss_chk.sv
// port-level checks on the top level, attached by bind
// depends on rmss_pkg and assert_macros.svh
`include "assert_macros.svh"

module rmss_chk
    import rmss_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    req_ready,
    input logic                    rsp_valid,
    input logic                    rsp_ready,
    input logic signed [SUM_W-1:0] best_sum,
    input logic                    range_error,
    input logic                    cfg_wr_en
);
    `ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
    `ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(best_sum) && $stable(range_error), "response changed while stalled")
    `ASSERT_IMPL(a_err_zero, rsp_valid && range_error, best_sum == '0, "error response with nonzero sum")
    `ASSERT_NEXT(a_cfg_clear, cfg_wr_en, !req_ready, "request taken during clearing sweep")
endmodule

bind range_max_subarray_sum_tree_top rmss_chk u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .best_sum    (rsp.best_sum),
    .range_error (rsp.range_error),
    .cfg_wr_en   (cfg_wr_en)
);

// File: sim/tb_range_max_subarray_sum_tree_top.sv
`timescale 1ns / 100ps
// self-checking bench for range_max_subarray_sum_tree_top: a directed table, then random
// set/query words, every response checked against a segment tree kept in the bench
// depends on rmss_pkg, rmss_req_if, rmss_rsp_if and the block's rtl
module tb_range_max_subarray_sum_tree_top;
    import rmss_pkg::*;

    localparam int CAP        = DEF_CAPACITY;
    localparam int SLOTS      = 4 * CAP;
    localparam int CYCLE_CAP  = 2000000;

    // one directed row; chk marks an expected result typed in by hand
    typedef struct {
        logic                    op;
        logic [LEN_W-1:0]        first;
        logic [LEN_W-1:0]        last;
        logic signed [VAL_W-1:0] val;
        logic                    chk;
        logic signed [SUM_W-1:0] want_sum;
        logic                    want_err;
    } row_t;

    typedef struct {
        logic signed [SUM_W-1:0] best_sum;
        logic                    range_error;
    } answer_t;

    // 64-bit span used by the bench tree
    typedef struct {
        longint total;
        longint pre;
        longint suf;
        longint inner;
    } seg_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [LEN_W-1:0] cfg_wr_data;

    rmss_req_if req ();
    rmss_rsp_if rsp ();

    range_max_subarray_sum_tree_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req.sink),
        .rsp         (rsp.source),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // bench copy of the tree and of the length register
    seg_t    tree [SLOTS];
    int      span_len;
    answer_t answers_due [$];
    int      errors;
    int      cycles;
    bit      no_idle;       // long stretch with no idling on either side
    bit      hold_rx;       // long receiver hold-off
    row_t    directed [$];

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // cycle counter and timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic longint bigger(longint a, longint b);
        return (a > b) ? a : b;
    endfunction

    function automatic seg_t combine(seg_t l, seg_t r);
        seg_t s;
        s.total = l.total + r.total;
        s.pre   = bigger(l.pre, l.total + r.pre);
        s.suf   = bigger(r.suf, r.total + l.suf);
        s.inner = bigger(bigger(l.inner, r.inner), l.suf + r.pre);
        return s;
    endfunction

    function automatic void wipe_tree();
        foreach (tree[k])
            tree[k] = '{0, 0, 0, 0};
    endfunction

    function automatic void put_leaf(int n, int b, int e, int pos, longint v);
        int mid;
        if (b == e)
        begin
            tree[n] = '{v, v, v, v};
            return;
        end
        mid = (b + e) / 2;
        if (pos <= mid)
            put_leaf(2 * n, b, mid, pos, v);
        else
            put_leaf(2 * n + 1, mid + 1, e, pos, v);
        tree[n] = combine(tree[2 * n], tree[2 * n + 1]);
    endfunction

    function automatic seg_t span_over(int n, int b, int e, int i, int j);
        int mid;
        if (b >= i && e <= j)
            return tree[n];
        mid = (b + e) / 2;
        if (j <= mid)
            return span_over(2 * n, b, mid, i, j);
        if (i > mid)
            return span_over(2 * n + 1, mid + 1, e, i, j);
        return combine(span_over(2 * n, b, mid, i, j),
                       span_over(2 * n + 1, mid + 1, e, i, j));
    endfunction

    // applies one accepted word to the bench tree, returns 1 with the answer for a query
    function automatic bit apply_word(logic op, int first, int last, longint v,
                                      output answer_t a);
        seg_t   s;
        longint best;
        a = '{0, 1'b0};
        if (op == OP_SET)
        begin
            if (first >= 1 && first <= span_len)
                put_leaf(1, 1, span_len, first, v);
            return 1'b0;
        end
        if (first == 0 || first > last || last > span_len)
        begin
            a = '{0, 1'b1};
            return 1'b1;
        end
        s = span_over(1, 1, span_len, first, last);
        best = s.inner;
        if (best > 134217727)
            best = 134217727;
        if (best < -134217728)
            best = -134217728;
        a.best_sum = best[SUM_W-1:0];
        return 1'b1;
    endfunction

    function automatic void set_length(int raw);
        int len;
        len = raw & 16'h1fff;
        if (len == 0)
            len = 1;
        if (len > CAP)
            len = CAP;
        span_len = len;
        wipe_tree();
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // offers one word and waits for its acceptance, idling at random first
    task automatic send_word(logic op, logic [LEN_W-1:0] first, logic [LEN_W-1:0] last,
                             logic signed [VAL_W-1:0] val, output bit fired);
        answer_t a;
        while (!no_idle && $urandom_range(99) < 16)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid       <= 1'b1;
        req.operation   <= op;
        req.first_index <= first;
        req.last_index  <= last;
        req.value       <= val;
        do
            @(posedge clk);
        while (!req.ready);
        fired = apply_word(op, first, last, val, a);
        if (fired)
            answers_due.push_back(a);
    endtask

    // stops offering, waits until every answer is in, then lets the block settle
    task automatic drain();
        req.valid <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    // writes the length register while idle; the block then sweeps the tree clear
    task automatic write_length(int raw);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= raw[LEN_W-1:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        set_length(raw);
    endtask

    // receiver: random stalls, a long hold-off on request; checks each answer word
    always @(posedge clk)
    begin
        if (rsp.valid && rsp.ready)
        begin
            if (answers_due.size() == 0)
                report("unexpected word best_sum", rsp.best_sum, 0);
            else
            begin
                if (rsp.best_sum !== answers_due[0].best_sum)
                    report("best_sum", rsp.best_sum, answers_due[0].best_sum);
                if (rsp.range_error !== answers_due[0].range_error)
                    report("range_error", rsp.range_error, answers_due[0].range_error);
                void'(answers_due.pop_front());
            end
        end
        rsp.ready <= !hold_rx && (no_idle || $urandom_range(99) >= 16);
    end

    // long receiver hold-off, counted here while the sender keeps offering
    task automatic hold_receiver();
        hold_rx = 1'b1;
        repeat (3000) @(posedge clk);
        hold_rx = 1'b0;
    endtask

    // random word, mostly well-formed; element values lean to small sizes and the extremes
    task automatic random_word();
        logic op;
        int   f;
        int   l;
        int   v;
        bit   fired;
        op = ($urandom_range(99) < 55) ? OP_SET : OP_QUERY;
        f  = $urandom_range(span_len, 1);
        l  = $urandom_range(span_len, f);
        if ($urandom_range(99) < 70 && span_len > 8)
            l = (f + $urandom_range(7) > span_len) ? span_len : f + $urandom_range(7);
        case ($urandom_range(19))
            0: f = 0;
            1: l = $urandom_range(8191);
            2: f = $urandom_range(8191);
            default: ;
        endcase
        case ($urandom_range(9))
            0: v = 32767;
            1: v = -32768;
            2: v = $urandom_range(65535);
            default: v = $urandom_range(600) - 300;
        endcase
        send_word(op, f[LEN_W-1:0], l[LEN_W-1:0], v[VAL_W-1:0], fired);
    endtask

    task automatic run_random(int count);
        repeat (count)
            random_word();
    endtask

    initial
    begin
        row_t r;
        bit   fired;
        answer_t a;
        errors      = 0;
        cycles      = 0;
        no_idle     = 0;
        hold_rx     = 0;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        req.valid       = 1'b0;
        req.operation   = OP_SET;
        req.first_index = '0;
        req.last_index  = '0;
        req.value       = '0;
        rsp.ready       = 1'b0;
        set_length(CAP);

        // op, first, last, value, hand-checked, sum, error
        directed.push_back('{OP_QUERY, 1, 4096, 0, 1, 0, 0});          // all zero after reset
        directed.push_back('{OP_QUERY, 0, 5, 0, 1, 0, 1});             // first of zero
        directed.push_back('{OP_QUERY, 9, 8, 0, 1, 0, 1});             // first above last
        directed.push_back('{OP_QUERY, 1, 4097, 0, 1, 0, 1});          // last beyond length
        directed.push_back('{OP_QUERY, 8191, 8191, 0, 1, 0, 1});       // top of the index field
        directed.push_back('{OP_SET, 1, 0, 16'sh7fff, 0, 0, 0});
        directed.push_back('{OP_QUERY, 1, 1, 0, 1, 32767, 0});
        directed.push_back('{OP_SET, 4096, 8191, -16'sd32768, 0, 0, 0});
        directed.push_back('{OP_QUERY, 4096, 4096, 0, 1, -32768, 0});
        directed.push_back('{OP_SET, 0, 0, 16'sd5, 0, 0, 0});          // bad set is dropped
        directed.push_back('{OP_SET, 4097, 0, 16'sd5, 0, 0, 0});       // bad set is dropped
        directed.push_back('{OP_SET, 8191, 0, 16'sd5, 0, 0, 0});
        directed.push_back('{OP_SET, 2048, 0, -16'sd3, 0, 0, 0});
        directed.push_back('{OP_SET, 2049, 0, 16'sd7, 0, 0, 0});
        directed.push_back('{OP_QUERY, 2048, 2049, 0, 0, 0, 0});       // straddles the root split
        directed.push_back('{OP_QUERY, 1, 4096, 0, 0, 0, 0});
        directed.push_back('{OP_QUERY, 4095, 4096, 0, 0, 0, 0});
        directed.push_back('{OP_QUERY, 2, 4095, 0, 0, 0, 0});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[k])
        begin
            r = directed[k];
            send_word(r.op, r.first, r.last, r.val, fired);
            if (fired && r.chk)
            begin
                a = answers_due[$];
                if (a.best_sum !== r.want_sum || a.range_error !== r.want_err)
                    report("table row", k, -1);
            end
        end

        // full length, with a stretch of no idling and a long receiver hold-off
        no_idle = 1;
        fork
            hold_receiver();
            run_random(200);
        join
        no_idle = 0;
        run_random(300);

        // small lengths, including the lowest
        write_length(1);
        run_random(150);
        write_length(0);                // zero behaves as one
        run_random(50);
        write_length(2);
        run_random(150);
        write_length(37);
        run_random(350);
        write_length(8191);             // saturates to capacity
        run_random(200);
        write_length(4096);
        run_random(130);

        drain();
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
